// ===== sv/ucpd_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 code point decoder.
package ucpd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0]  ASCII_MAX      = 8'd127;
    localparam logic [7:0]  LEAD2_MIN      = 8'd192;
    localparam logic [7:0]  LEAD2_MAX      = 8'd223;
    localparam logic [7:0]  LEAD3_MIN      = 8'd224;
    localparam logic [7:0]  LEAD3_MAX      = 8'd239;
    localparam logic [7:0]  LEAD4_MIN      = 8'd240;
    localparam logic [7:0]  LEAD4_MAX      = 8'd247;
    localparam logic [7:0]  LEAD_SURROGATE = 8'hED;
    localparam logic [7:0]  SURROGATE_MASK = 8'hA0;
    localparam logic [31:0] CP_ERROR       = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_TWO,
        KIND_THREE,
        KIND_FOUR,
        KIND_BAD
    } ucpd_kind_t;

    typedef struct packed {
        ucpd_kind_t kind;
        logic [7:0] lead;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
    } ucpd_entry_t;

    // byte - 128 in two's complement, sign-extended to 32 bits
    function automatic logic [31:0] cont_val(input logic [7:0] b);
        return {{24{~b[7]}}, ~b[7], b[6:0]};
    endfunction

endpackage

// ===== sv/ucpd_front.sv =====
// Front end: accepts bytes, tracks the sequence and classifies finished sequences.
module ucpd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output logic                 entry_valid,
    output ucpd_pkg::ucpd_entry_t entry
);
    import ucpd_pkg::*;

    typedef enum logic [1:0] {
        POS_LEAD,
        POS_SECOND,
        POS_THIRD,
        POS_FOURTH
    } pos_t;

    pos_t       pos_reg, pos_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] third_reg, third_next;

    always_comb
    begin
        pos_next    = pos_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        third_next  = third_reg;
        entry_valid = 1'b0;
        entry.kind  = KIND_BAD;
        entry.lead  = lead_reg;
        entry.byte2 = second_reg;
        entry.byte3 = third_reg;
        entry.byte4 = in_byte;
        if (in_valid)
        begin
            case (pos_reg)
                POS_LEAD:
                begin
                    if (in_byte <= ASCII_MAX)
                    begin
                        entry_valid = 1'b1;
                        entry.kind  = KIND_ASCII;
                    end
                    else
                    begin
                        lead_next = in_byte;
                        pos_next  = POS_SECOND;
                    end
                end
                POS_SECOND:
                begin
                    second_next = in_byte;
                    if (lead_reg inside {[LEAD2_MIN:LEAD2_MAX]})
                    begin
                        entry_valid = 1'b1;
                        entry.kind  = KIND_TWO;
                        pos_next    = POS_LEAD;
                    end
                    else if (lead_reg == LEAD_SURROGATE &&
                             (in_byte & SURROGATE_MASK) == SURROGATE_MASK)
                    begin
                        entry_valid = 1'b1;
                        entry.kind  = KIND_BAD;
                        pos_next    = POS_LEAD;
                    end
                    else
                    begin
                        pos_next = POS_THIRD;
                    end
                end
                POS_THIRD:
                begin
                    third_next = in_byte;
                    if (lead_reg inside {[LEAD3_MIN:LEAD3_MAX]})
                    begin
                        entry_valid = 1'b1;
                        entry.kind  = KIND_THREE;
                        entry.byte3 = second_reg;
                        pos_next    = POS_LEAD;
                    end
                    else
                    begin
                        pos_next = POS_FOURTH;
                    end
                end
                POS_FOURTH:
                begin
                    entry_valid = 1'b1;
                    entry.kind  = (lead_reg inside {[LEAD4_MIN:LEAD4_MAX]}) ?
                                  KIND_FOUR : KIND_BAD;
                    pos_next    = POS_LEAD;
                end
                default:
                begin
                    pos_next = POS_LEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_LEAD;
            lead_reg   <= '0;
            second_reg <= '0;
            third_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            lead_reg   <= lead_next;
            second_reg <= second_next;
            third_reg  <= third_next;
        end
    end

    a_fourth_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && pos_reg == POS_FOURTH) |=> pos_reg == POS_LEAD)
        else $error("sequence did not end after fourth byte");

    a_entry_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid |-> in_valid)
        else $error("entry produced without a byte");

endmodule

// ===== sv/ucpd_queue.sv =====
// Short queue of classified sequences between front and back end.
module ucpd_queue #(
    parameter int unsigned DEPTH = ucpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  ucpd_pkg::ucpd_entry_t wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output logic                  not_empty,
    output ucpd_pkg::ucpd_entry_t rd_data
);
    import ucpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ucpd_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !not_empty))
        else $error("read from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ===== sv/ucpd_back.sv =====
// Back end: assembles code points from classified sequences into the output register.
module ucpd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  ucpd_pkg::ucpd_entry_t job,
    output logic                  job_take,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           code_point,
    output logic                  bad_sequence
);
    import ucpd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] code_point_reg, code_point_next;
    logic        bad_reg, bad_next;
    logic [31:0] cp_calc;
    logic        bad_calc;
    logic [31:0] cont2;
    logic [31:0] cont3;
    logic [31:0] cont4;

    assign cont2 = cont_val(job.byte2);
    assign cont3 = cont_val(job.byte3);
    assign cont4 = cont_val(job.byte4);

    always_comb
    begin
        bad_calc = 1'b0;
        case (job.kind)
            KIND_ASCII:
            begin
                cp_calc = {24'd0, job.byte4};
            end
            KIND_TWO:
            begin
                cp_calc = {21'd0, job.lead[4:0], 6'd0} + cont4;
            end
            KIND_THREE:
            begin
                cp_calc = {16'd0, job.lead[3:0], 12'd0}
                        + {cont3[25:0], 6'd0}
                        + cont4;
            end
            KIND_FOUR:
            begin
                cp_calc = {11'd0, job.lead[2:0], 18'd0}
                        + {cont2[19:0], 12'd0}
                        + {cont3[25:0], 6'd0}
                        + cont4;
            end
            default:
            begin
                cp_calc  = CP_ERROR;
                bad_calc = 1'b1;
            end
        endcase
    end

    assign job_take     = job_valid && (!out_valid_reg || pop);
    assign empty        = !out_valid_reg;
    assign code_point   = code_point_reg;
    assign bad_sequence = bad_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        code_point_next = code_point_reg;
        bad_next        = bad_reg;
        if (job_take)
        begin
            out_valid_next  = 1'b1;
            code_point_next = cp_calc;
            bad_next        = bad_calc;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_point_reg <= code_point_next;
        bad_reg        <= bad_next;
    end

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> !empty)
        else $error("taken job did not reach output");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(bad_sequence)))
        else $error("stalled item changed");

    a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_sequence) |-> code_point == CP_ERROR)
        else $error("error item without error code");

endmodule

// ===== sv/utf8_code_point_decoder.sv =====
// Top level of the UTF-8 code point decoder.
// A result is written into the queue at the edge that accepts its final byte, then moves
// to the output register once that is empty or being popped, and can then be popped.
// Throughput: one byte per cycle while full is low; the queue between front and back end sets
// how long the input keeps taking bytes while results are not popped.
// Reset (rst_n low, asynchronous) clears the sequence state, the queue and the output valid flag.
module utf8_code_point_decoder #(
    parameter int unsigned QUEUE_DEPTH = ucpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] code_point,
    output logic        bad_sequence
);
    import ucpd_pkg::*;

    logic        accept;
    logic        entry_valid;
    ucpd_entry_t entry;
    logic        q_not_empty;
    ucpd_entry_t q_head;
    logic        q_take;

    assign accept = push && !full;

    ucpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .in_byte     (in_byte),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    ucpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (entry_valid),
        .wr_data   (entry),
        .full      (full),
        .rd_en     (q_take),
        .not_empty (q_not_empty),
        .rd_data   (q_head)
    );

    ucpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job          (q_head),
        .job_take     (q_take),
        .empty        (empty),
        .pop          (pop),
        .code_point   (code_point),
        .bad_sequence (bad_sequence)
    );

endmodule
